### hdl/u2a_pkg.sv
// shared constants, types and helpers of the unsigned to ascii converter
package u2a_pkg;

  // input field widths
  localparam int VALUE_IN_W = 64;
  localparam int OPCODE_W   = 2;
  localparam int SIZE_W     = 2;
  localparam int CHAR_W     = 8;

  // significant bits of the incoming value
  localparam int VALUE_WIDTH = 64;

  // digit counts for the three radixes
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int MAX_DIGITS = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;

  // digit shift register, left aligned, also holds the bcd result
  localparam int SH_W      = 4 * DEC_DIGITS;
  localparam int HEX_SHIFT = SH_W - 4 * HEX_DIGITS;
  localparam int OCT_SHIFT = SH_W - 3 * OCT_DIGITS;

  // double dabble consumes four value bits per cycle
  localparam int DD_CYCLES = HEX_DIGITS;
  localparam int BIN_W     = 4 * DD_CYCLES;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DD_W  = $clog2(DD_CYCLES + 1);

  // radix codes
  localparam logic [OPCODE_W-1:0] OP_DEC    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_OCT    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HEX_LO = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_HEX_UP = 2'd3;

  // size truncation codes, the unused code acts as 32 bits
  localparam logic [SIZE_W-1:0] SZ_32 = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_64 = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_16 = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  typedef struct packed {
    logic load;
    logic dd_step;
    logic put_pre0;
    logic put_prex;
    logic scan_step;
  } u2a_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic is_hex;
    logic dd_done;
    logic prefix_en;
    logic scan_emit;
    logic scan_last;
    logic out_free;
  } u2a_sts_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] dig,
                                                     input logic upper);
    logic [CHAR_W-1:0] base;
    if (dig < 4'd10) begin
      digit_ascii = CH_ZERO + CHAR_W'(dig);
    end else begin
      base        = upper ? CH_UP_A : CH_LO_A;
      digit_ascii = base + CHAR_W'(dig - 4'd10);
    end
  endfunction

endpackage

### hdl/u2a_in_if.sv
// input channel: number, radix, alternate form and size selector
interface u2a_in_if import u2a_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_IN_W-1:0] value;
  logic [OPCODE_W-1:0]   opcode;
  logic                  alternate_form;
  logic [SIZE_W-1:0]     size_mode;

  modport source (output valid, value, opcode, alternate_form, size_mode, input ready);
  modport sink   (input valid, value, opcode, alternate_form, size_mode, output ready);
endinterface

### hdl/u2a_out_if.sv
// result channel: one ascii character per item
interface u2a_out_if import u2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, digit_char, last, input ready);
  modport sink   (input valid, digit_char, last, output ready);
endinterface

### hdl/u2a_ctrl.sv
// controller state machine of the unsigned to ascii converter
module u2a_ctrl import u2a_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  u2a_sts_t sts,
  output u2a_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_PRE0 = 5'b00100,
    ST_PREX = 5'b01000,
    ST_SCAN = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.is_dec && !sts.dd_done) begin
          cmd.dd_step = 1'b1;
        end else if (sts.prefix_en) begin
          state_nxt = ST_PRE0;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_PRE0: begin
        if (sts.out_free) begin
          cmd.put_pre0 = 1'b1;
          state_nxt    = sts.is_hex ? ST_PREX : ST_SCAN;
        end
      end
      ST_PREX: begin
        if (sts.out_free) begin
          cmd.put_prex = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // leading zeros are dropped without waiting on the output
        if (!sts.scan_emit || sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/u2a_dp.sv
// datapath: truncation, double dabble, digit shifter and output register
module u2a_dp import u2a_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u2a_cmd_t              cmd,
  input  logic [VALUE_IN_W-1:0] in_value,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic                  in_alternate_form,
  input  logic [SIZE_W-1:0]     in_size_mode,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last,
  output u2a_sts_t              sts
);

  localparam logic [VALUE_WIDTH-1:0] MASK_16 = VALUE_WIDTH'(64'h0000_0000_0000_FFFF);
  localparam logic [VALUE_WIDTH-1:0] MASK_32 = VALUE_WIDTH'(64'h0000_0000_FFFF_FFFF);

  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic                prefix_r, prefix_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;
  logic [SH_W-1:0]     sh_r, sh_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                seen_r, seen_nxt;
  logic [DD_W-1:0]     dd_cnt_r, dd_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] orig;
  logic [VALUE_WIDTH-1:0] trunc;
  logic [SH_W-1:0]        sh_load;
  logic [CNT_W-1:0]       cnt_load;
  logic [SH_W-1:0]        bcd_v;
  logic [BIN_W-1:0]       bin_v;
  logic                   is_oct;
  logic [3:0]             dig;
  logic                   load_out;

  // size truncation of the incoming number
  assign orig = in_value[VALUE_WIDTH-1:0];

  always_comb begin
    case (in_size_mode)
      SZ_64:   trunc = orig;
      SZ_16:   trunc = orig & MASK_16;
      default: trunc = orig & MASK_32;
    endcase
  end

  // left aligned digit image, bcd starts empty
  always_comb begin
    case (in_opcode)
      OP_DEC: begin
        sh_load  = '0;
        cnt_load = CNT_W'(DEC_DIGITS);
      end
      OP_OCT: begin
        sh_load  = SH_W'(trunc) << OCT_SHIFT;
        cnt_load = CNT_W'(OCT_DIGITS);
      end
      default: begin
        sh_load  = SH_W'(trunc) << HEX_SHIFT;
        cnt_load = CNT_W'(HEX_DIGITS);
      end
    endcase
  end

  // four double dabble iterations
  always_comb begin
    bcd_v = sh_r;
    bin_v = bin_r;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (bcd_v[4*d +: 4] >= 4'd5) begin
          bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v[SH_W-2:0], bin_v, 1'b0};
    end
  end

  assign is_oct = (op_r == OP_OCT);
  assign dig    = is_oct ? {1'b0, sh_r[SH_W-1 -: 3]} : sh_r[SH_W-1 -: 4];

  assign sts.is_dec    = (op_r == OP_DEC);
  assign sts.is_hex    = (op_r == OP_HEX_LO) || (op_r == OP_HEX_UP);
  assign sts.dd_done   = (dd_cnt_r == '0);
  assign sts.prefix_en = prefix_r;
  assign sts.scan_last = (cnt_r == CNT_W'(1));
  assign sts.scan_emit = (dig != 4'd0) || seen_r || sts.scan_last;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign load_out = cmd.put_pre0 || cmd.put_prex || (cmd.scan_step && sts.scan_emit);

  always_comb begin
    op_nxt     = op_r;
    prefix_nxt = prefix_r;
    bin_nxt    = bin_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    dd_cnt_nxt = dd_cnt_r;
    if (cmd.load) begin
      op_nxt     = in_opcode;
      prefix_nxt = in_alternate_form && (orig != '0) && (in_opcode != OP_DEC);
      bin_nxt    = BIN_W'(trunc);
      sh_nxt     = sh_load;
      cnt_nxt    = cnt_load;
      seen_nxt   = 1'b0;
      dd_cnt_nxt = DD_W'(DD_CYCLES);
    end else if (cmd.dd_step) begin
      bin_nxt    = bin_v;
      sh_nxt     = bcd_v;
      dd_cnt_nxt = dd_cnt_r - DD_W'(1);
    end else if (cmd.scan_step) begin
      sh_nxt   = is_oct ? (sh_r << 3) : (sh_r << 4);
      cnt_nxt  = cnt_r - CNT_W'(1);
      seen_nxt = seen_r || (dig != 4'd0);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = cmd.scan_step && sts.scan_last;
      if (cmd.put_pre0) begin
        out_char_nxt = CH_ZERO;
      end else if (cmd.put_prex) begin
        out_char_nxt = (op_r == OP_HEX_UP) ? CH_UP_X : CH_LO_X;
      end else begin
        out_char_nxt = digit_ascii(dig, op_r == OP_HEX_UP);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dd_cnt_r    <= '0;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      prefix_r    <= 1'b0;
      op_r        <= OP_DEC;
    end else begin
      out_valid_r <= out_valid_nxt;
      dd_cnt_r    <= dd_cnt_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      prefix_r    <= prefix_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    sh_r       <= sh_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

### hdl/unsigned_to_ascii_radix.sv
// top level of the unsigned to ascii converter
// usage:
//   in_chan carries one number per item: value, opcode (decimal, octal,
//   lower hex, upper hex), alternate_form and size_mode (32, 64 or 16 bits)
//   out_chan returns the ascii characters of that number, most significant
//   first, one per item, with last set on the final character
//   in alternate form octal gets a leading 0 and hex a leading 0x or 0X,
//   decided on the value before size truncation
// throughput:
//   one number is worked on at a time; the digit shifter emits one digit
//   position per cycle, leading zeros included, unless a digit waits on a
//   stalled out_chan, and decimal first runs double dabble on four value
//   bits per cycle
//   the next number is taken while the final character still waits
//   in the output register
// reset and stall:
//   rst_n is synchronous and active low; it drops any number in flight
//   and empties the output register
//   when out_chan stalls, the character is held and the conversion waits
//   on it; in_chan stays not ready until the number has been issued
module unsigned_to_ascii_radix import u2a_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  u2a_in_if.sink    in_chan,
  u2a_out_if.source out_chan
);

  u2a_cmd_t cmd;
  u2a_sts_t sts;
  logic     in_ready;

  // sequencing of load, conversion, prefix and digit scan
  u2a_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // number registers, bcd conversion and character output register
  u2a_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_value          (in_chan.value),
    .in_opcode         (in_chan.opcode),
    .in_alternate_form (in_chan.alternate_form),
    .in_size_mode      (in_chan.size_mode),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_digit_char    (out_chan.digit_char),
    .out_last          (out_chan.last),
    .sts               (sts)
  );

  assign in_chan.ready = in_ready;

`ifndef ASSERT_OFF
  // an accepted number closes the input in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready |=> !in_chan.ready)
    else $error("input ready right after an accepted item");

  // a prefix character only when the prefix was requested
  a_prefix_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_pre0 || cmd.put_prex) |-> sts.prefix_en)
    else $error("prefix issued without alternate form");

  // the final digit goes out flagged and frees the input
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step && sts.scan_last |=> in_chan.ready && out_chan.valid && out_chan.last)
    else $error("final digit not issued with last");
`endif

endmodule

### tb/tb_unsigned_to_ascii_radix.sv
// self-checking testbench of the unsigned to ascii radix converter
`timescale 1ns / 100ps

module tb_unsigned_to_ascii_radix;
  import u2a_pkg::*;

  // no accepted item on either side for this many cycles ends the run
  localparam int WATCHDOG_LIMIT = 5000;
  // settle time after the last character, well above the decimal latency
  localparam int TAIL_CYCLES    = 80;
  localparam int RANDOM_NUMS    = 107;
  // percent of cycles in which a side idles
  localparam int IDLE_PCT       = 11;
  // random number that waits for the converter to drain before it is sent
  localparam int DRAIN_AT       = 70;
  // window of accepted numbers in which neither side idles
  localparam int CALM_FROM      = 60;
  localparam int CALM_TO        = 100;

  // the size code the converter does not define, taken as 32 bits
  localparam logic [SIZE_W-1:0] SZ_SPARE = 2'd3;
  localparam logic [VALUE_IN_W-1:0] ALL_ONES = '1;

  // one number as the sender holds it, plus a flag to hold it back until
  // every character predicted so far has been seen
  typedef struct packed {
    logic [VALUE_IN_W-1:0] value;
    logic [OPCODE_W-1:0]   opcode;
    logic                  alternate_form;
    logic [SIZE_W-1:0]     size_mode;
    logic                  drain_first;
  } num_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } char_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  u2a_in_if  in_bus ();
  u2a_out_if out_bus ();

  unsigned_to_ascii_radix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  num_item_t  pending_nums[$];
  char_item_t expected_chars[$];

  logic in_fire       = 1'b0;
  int   nums_accepted = 0;
  int   stall_cycles  = 0;
  int   mismatches    = 0;
  logic calm;

  // long stretch in the middle of the run with no idling on either side
  assign calm = (nums_accepted >= CALM_FROM) && (nums_accepted < CALM_TO);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // character stream for one number: the kept bits pick the digits, the
  // masked but untruncated value decides the prefix
  function automatic void predict_chars(input num_item_t num_in);
    logic [VALUE_IN_W-1:0] kept;
    logic [VALUE_IN_W-1:0] num;
    logic [VALUE_IN_W-1:0] radix;
    logic [VALUE_IN_W-1:0] dig;
    logic [CHAR_W-1:0]     rev [0:22];
    logic                  upper;
    char_item_t            exp_char;
    int                    n;
    kept = (VALUE_WIDTH >= VALUE_IN_W) ? num_in.value :
           num_in.value & ((64'd1 << VALUE_WIDTH) - 64'd1);
    case (num_in.size_mode)
      SZ_64:   num = kept;
      SZ_16:   num = {48'd0, kept[15:0]};
      default: num = {32'd0, kept[31:0]};   // 32 bits, spare code too
    endcase
    case (num_in.opcode)
      OP_DEC:  radix = 64'd10;
      OP_OCT:  radix = 64'd8;
      default: radix = 64'd16;
    endcase
    upper = (num_in.opcode == OP_HEX_UP);
    n = 0;
    // digits collected least significant first
    if (num == 64'd0) begin
      rev[0] = CH_ZERO;
      n = 1;
    end
    while (num != 64'd0) begin
      dig = num % radix;
      if (dig < 64'd10) begin
        rev[n] = CH_ZERO + CHAR_W'(dig);
      end else begin
        rev[n] = (upper ? CH_UP_A : CH_LO_A) + CHAR_W'(dig - 64'd10);
      end
      n = n + 1;
      num = num / radix;
    end
    // prefix goes on the reversed end so it comes out first
    if (num_in.alternate_form && kept != 64'd0) begin
      case (num_in.opcode)
        OP_OCT: begin
          rev[n] = CH_ZERO;
          n = n + 1;
        end
        OP_HEX_LO, OP_HEX_UP: begin
          rev[n] = upper ? CH_UP_X : CH_LO_X;
          rev[n + 1] = CH_ZERO;
          n = n + 2;
        end
        default: ;   // decimal takes no prefix
      endcase
    end
    for (int k = 0; k < n; k++) begin
      exp_char.digit_char = rev[n - 1 - k];
      exp_char.last       = (k == n - 1);
      expected_chars.push_back(exp_char);
    end
  endfunction

  function automatic void add_num(input logic [VALUE_IN_W-1:0] value,
                                  input logic [OPCODE_W-1:0] opcode,
                                  input logic alt,
                                  input logic [SIZE_W-1:0] size_mode,
                                  input logic drain_first);
    num_item_t item;
    item.value          = value;
    item.opcode         = opcode;
    item.alternate_form = alt;
    item.size_mode      = size_mode;
    item.drain_first    = drain_first;
    pending_nums.push_back(item);
  endfunction

  // random number with a bias toward shapes that hit the corner cases
  function automatic num_item_t random_num();
    num_item_t item;
    int        shape;
    shape = $urandom_range(0, 9);
    case (shape)
      5, 6:    item.value = 64'($urandom_range(0, 1000));
      7: begin
        // only bits above the low 32 or 16 set, so the prefix can show on a truncated zero
        if ($urandom_range(0, 1) == 0) begin
          item.value = {$urandom, 32'd0};
        end else begin
          item.value = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000;
        end
      end
      8:       item.value = 64'd1 << $urandom_range(0, 63);
      9:       item.value = ALL_ONES >> $urandom_range(0, 63);
      default: item.value = {$urandom, $urandom};
    endcase
    item.opcode         = OPCODE_W'($urandom_range(0, 3));
    item.alternate_form = 1'($urandom_range(0, 1));
    item.size_mode      = SIZE_W'($urandom_range(0, 3));
    item.drain_first    = 1'b0;
    return item;
  endfunction

  // sender: a new number goes out at the falling edge once the slot is free;
  // a number on the bus is held untouched until it is taken
  always @(negedge clk) begin : send_nums
    logic next_valid;
    num_item_t next_num;
    next_valid = in_bus.valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      next_valid = 1'b0;
      if (pending_nums.size() != 0 &&
          !(pending_nums[0].drain_first && expected_chars.size() != 0) &&
          (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_num = pending_nums.pop_front();
        in_bus.value          <= next_num.value;
        in_bus.opcode         <= next_num.opcode;
        in_bus.alternate_form <= next_num.alternate_form;
        in_bus.size_mode      <= next_num.size_mode;
        next_valid = 1'b1;
      end
    end
    in_bus.valid <= next_valid;
  end

  // receiver: ready drops at random outside the calm window
  always @(negedge clk) begin
    out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // both handshakes are sampled at the rising edge: accepted numbers feed
  // the predictor, accepted characters are checked against the oldest
  // expectation, and the watchdog watches for a hang
  always @(posedge clk) begin : watch_bus
    num_item_t  seen;
    char_item_t want;
    logic       in_take;
    logic       out_take;
    in_take  = rst_n && in_bus.valid && in_bus.ready;
    out_take = rst_n && out_bus.valid && out_bus.ready;
    in_fire <= in_take;
    if (in_take) begin
      seen.value          = in_bus.value;
      seen.opcode         = in_bus.opcode;
      seen.alternate_form = in_bus.alternate_form;
      seen.size_mode      = in_bus.size_mode;
      seen.drain_first    = 1'b0;
      predict_chars(seen);
      nums_accepted <= nums_accepted + 1;
    end
    if (out_take) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character item %h last %b",
               out_bus.digit_char, out_bus.last);
        mismatches = mismatches + 1;
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.digit_char !== want.digit_char) begin
          $error("digit_char mismatch: expected %h, got %h",
                 want.digit_char, out_bus.digit_char);
          mismatches = mismatches + 1;
        end
        if (out_bus.last !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, out_bus.last);
          mismatches = mismatches + 1;
        end
      end
    end
    if (!rst_n || in_take || out_take) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT - 1) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    num_item_t item;
    in_bus.valid          = 1'b0;
    in_bus.value          = '0;
    in_bus.opcode         = OP_DEC;
    in_bus.alternate_form = 1'b0;
    in_bus.size_mode      = SZ_32;
    out_bus.ready         = 1'b0;

    // zero in every radix: single '0', no prefix even in alternate form
    add_num(64'd0, OP_DEC,    1'b1, SZ_64,    1'b0);
    add_num(64'd0, OP_OCT,    1'b1, SZ_32,    1'b0);
    add_num(64'd0, OP_HEX_LO, 1'b1, SZ_16,    1'b0);
    add_num(64'd0, OP_HEX_UP, 1'b0, SZ_SPARE, 1'b0);
    // full 64 bits; octal with prefix gives the longest stream
    add_num(ALL_ONES, OP_DEC,    1'b1, SZ_64, 1'b0);
    add_num(ALL_ONES, OP_OCT,    1'b1, SZ_64, 1'b0);
    add_num(ALL_ONES, OP_HEX_LO, 1'b1, SZ_64, 1'b0);
    add_num(ALL_ONES, OP_HEX_UP, 1'b1, SZ_64, 1'b0);
    // nonzero value truncated to zero still gets its prefix; decimal takes none
    add_num(64'h1_0000_0000, OP_OCT,    1'b1, SZ_32,    1'b0);
    add_num(64'h1_0000_0000, OP_HEX_LO, 1'b1, SZ_32,    1'b0);
    add_num(64'h1_0000_0000, OP_HEX_UP, 1'b1, SZ_SPARE, 1'b0);
    add_num(64'h1_0000_0000, OP_DEC,    1'b1, SZ_32,    1'b0);
    add_num(64'h1_0000,      OP_HEX_UP, 1'b1, SZ_16,    1'b0);
    // spare size code keeps 32 bits, 16-bit truncation
    add_num(64'hDEAD_BEEF_1234_5678, OP_HEX_UP, 1'b0, SZ_SPARE, 1'b0);
    add_num(64'hFFFF_FFFF_FFFF_ABCD, OP_HEX_LO, 1'b0, SZ_16,    1'b0);
    // top bit alone and other edge values; the first of these waits for the converter to drain
    add_num(64'h8000_0000_0000_0000, OP_DEC, 1'b0, SZ_64, 1'b1);
    add_num(64'h8000_0000_0000_0000, OP_OCT, 1'b1, SZ_64, 1'b0);
    add_num(64'd1,                   OP_OCT, 1'b1, SZ_32, 1'b0);
    add_num(64'hFFFF_FFFF,           OP_DEC, 1'b0, SZ_32, 1'b0);
    add_num(64'hFFFF,                OP_OCT, 1'b1, SZ_16, 1'b0);
    add_num(64'h0123_4567_89AB_CDEF, OP_HEX_LO, 1'b1, SZ_64, 1'b0);
    add_num(64'hFEDC_BA98_7654_3210, OP_HEX_UP, 1'b1, SZ_64, 1'b0);
    add_num(64'd9,                   OP_DEC, 1'b0, SZ_SPARE, 1'b0);

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      item = random_num();
      item.drain_first = (i == DRAIN_AT);
      pending_nums.push_back(item);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all numbers sent, then every predicted character seen
    while (pending_nums.size() != 0 || in_bus.valid) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    // catch any stray character after the stream should have ended
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
